@@ hw/rtl/best_fit_block_allocator_defines.svh @@
// Assertion macros used by the checker of the block allocator.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFBA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bfba_pkg.sv @@
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared widths, codes and types of the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfba_pkg;

    localparam int START_W     = 12;
    localparam int LEN_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 128;
    localparam int M_TUSER_W   = 2;
    localparam int ENTRY_W     = START_W + LEN_W;

    localparam int DEF_NUM_BLOCKS      = 4096;
    localparam int DEF_MAX_FREE_GROUPS = 2048;
    localparam int DEF_SEARCH_WINDOW   = 100;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'b1;

    localparam logic [START_W-1:0] RST_RESERVED = 12'd2;
    localparam logic [LEN_W-1:0]   RST_TOTAL    = 13'd4096;

    // Result of comparing one free-list entry against the current request.
    typedef struct packed {
        logic             len_eq;
        logic             len_ge;
        logic             better;
        logic             overlap;
        logic             p_hit;
        logic             q_hit;
        logic             bigger;
        logic [LEN_W-1:0] sub;
    } cmp_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/best_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator of fixed-size blocks over an ordered list of free groups.
// ----------------------------------------------------------------------------
// The block takes one request item on the s_ channel and returns one result
// item on the m_ channel. An allocate request searches the free list for the
// best fit within the first SEARCH_WINDOW+1 entries and goes on first-fit past
// that window; a free request merges the group with free neighbors and adds
// the merged group at the list tail. Every result carries the status, the
// start block of an allocated group and the running statistics.
// All work runs through one compare unit and the list memory, which has one
// write port and one read port; list entries are read and tested one at a
// time. A request scans the list for the search or the neighbors, closes the
// gaps left by removed entries (a free that merges on both sides removes two)
// and scans for the largest free group. s_tready is low while a request is
// worked. A finished result waits in the output register while m_tready is
// low; the block then takes a new request but holds its result until the
// first leaves. After reset, and after every configuration write, the ST_INIT
// state rebuilds the list as a single free group, or as an empty list when
// the header fills the store; there is no clearing pass over the memory.
// Configuration is taken only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_allocator import bfba_pkg::*; #(
    parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS,
    parameter int MAX_FREE_GROUPS = DEF_MAX_FREE_GROUPS,
    parameter int SEARCH_WINDOW   = DEF_SEARCH_WINDOW
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Request channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: block_count[12:0], start_block[24:13], api_object[25], zero fill.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: func[0].
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata: start_out[11:0], allocated_blocks[24:12], group_count[37:25],
    // api_objects[50:38], alloc_calls[82:51], free_calls[114:83],
    // largest_free_blocks[127:115].
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // tuser: status[1:0].
    output logic      [M_TUSER_W-1:0]  m_tuser,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_FREE_GROUPS);
    localparam int CNT_W = $clog2(MAX_FREE_GROUPS + 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_AL_RD,
        ST_AL_EV,
        ST_AL_UPD,
        ST_FR_RD,
        ST_FR_EV,
        ST_FR_DEC,
        ST_RM_START,
        ST_RM_RD,
        ST_RM_WR,
        ST_APPEND,
        ST_LG_RD,
        ST_LG_EV,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration and the clamped values that the allocator works with.
    logic [START_W-1:0] reserved_reg;
    logic [LEN_W-1:0]   total_reg;
    logic [LEN_W-1:0]   eff_total;
    logic [START_W-1:0] eff_res;
    logic [START_W-1:0] res_min1;

    // Request.
    logic               func_reg;
    logic [LEN_W-1:0]   cnt_reg;
    logic [START_W-1:0] sb_reg;
    logic               api_reg;
    logic [LEN_W:0]     end_blk;

    // List walk.
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   n_reg;

    // Search results.
    logic               best_vld_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [START_W-1:0] best_start_reg;
    logic [LEN_W-1:0]   best_len_reg;
    logic [LEN_W-1:0]   diff_reg;
    logic               p_vld_reg;
    logic               q_vld_reg;
    logic [IDX_W-1:0]   p_idx_reg;
    logic [IDX_W-1:0]   q_idx_reg;
    logic [START_W-1:0] p_start_reg;
    logic [LEN_W-1:0]   p_len_reg;
    logic [LEN_W-1:0]   q_len_reg;
    logic [START_W-1:0] ns_reg;
    logic [LEN_W-1:0]   nl_reg;
    logic [IDX_W-1:0]   rm_idx_reg;
    logic [IDX_W-1:0]   rm2_idx_reg;
    logic               rm_pend_reg;

    // Statistics and result.
    logic [1:0]         status_reg;
    logic [START_W-1:0] start_out_reg;
    logic [LEN_W-1:0]   alloc_tot_reg;
    logic [LEN_W-1:0]   grp_tot_reg;
    logic [LEN_W-1:0]   api_tot_reg;
    logic [31:0]        alloc_cnt_reg;
    logic [31:0]        free_cnt_reg;
    logic [LEN_W-1:0]   largest_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // Memory and compare unit.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [START_W-1:0] ent_start;
    logic [LEN_W-1:0]   ent_len;
    cmp_res_t           cmp;

    // Request fields as they arrive.
    logic               in_func;
    logic [LEN_W-1:0]   in_cnt;
    logic [START_W-1:0] in_sb;
    logic               in_api;
    logic               in_bad_range;

    logic               in_win;
    logic               at_win_end;

    // The total is clamped to the store size, the header to one block at
    // least and to the clamped total at most.
    always_comb begin
        if (32'(total_reg) > 32'(NUM_BLOCKS)) begin
            eff_total = LEN_W'(NUM_BLOCKS);
        end else begin
            eff_total = total_reg;
        end
        res_min1 = (reserved_reg == '0) ? START_W'(1) : reserved_reg;
        if ({1'b0, res_min1} > eff_total) begin
            eff_res = eff_total[START_W-1:0];
        end else begin
            eff_res = res_min1;
        end
    end

    assign in_func      = s_tuser[0];
    assign in_cnt       = s_tdata[12:0];
    assign in_sb        = s_tdata[24:13];
    assign in_api       = s_tdata[25];
    assign in_bad_range = (in_sb < eff_res)
                       || (({2'b00, in_sb} + {1'b0, in_cnt}) > {1'b0, eff_total});

    assign end_blk    = {2'b00, sb_reg} + {1'b0, cnt_reg};
    assign in_win     = 32'(i_reg) <= 32'(SEARCH_WINDOW);
    assign at_win_end = 32'(i_reg) == (32'(SEARCH_WINDOW) + 32'd1);

    assign ent_start = ram_rdata[START_W-1:0];
    assign ent_len   = ram_rdata[ENTRY_W-1:START_W];

    bfba_list_ram #(
        .DEPTH (MAX_FREE_GROUPS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    bfba_cmp u_cmp (
        .ent_start (ent_start),
        .ent_len   (ent_len),
        .want      (cnt_reg),
        .sb        (sb_reg),
        .end_blk   (end_blk),
        .diff      (diff_reg),
        .largest   (largest_reg),
        .res       (cmp)
    );

    // List memory writes: the rebuilt first group, a shrunk group, one step of
    // closing a gap, or the merged group appended at the tail.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {eff_total - {1'b0, eff_res}, eff_res};
        unique case (state_reg)
            ST_INIT: begin
                ram_we = eff_total > {1'b0, eff_res};
            end
            ST_AL_UPD: begin
                ram_we    = best_len_reg != cnt_reg;
                ram_waddr = best_idx_reg;
                ram_wdata = {best_len_reg - cnt_reg, best_start_reg + cnt_reg[START_W-1:0]};
            end
            ST_RM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[IDX_W-1:0] - IDX_W'(1);
                ram_wdata = ram_rdata;
            end
            ST_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = n_reg[IDX_W-1:0];
                ram_wdata = {nl_reg, ns_reg};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = state_reg == ST_IDLE;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            reserved_reg  <= RST_RESERVED;
            total_reg     <= RST_TOTAL;
            n_reg         <= '0;
            i_reg         <= '0;
            rm_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            alloc_tot_reg <= '0;
            grp_tot_reg   <= '0;
            api_tot_reg   <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
        end else begin
            // In ST_OUT the output register is reloaded instead.
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT: begin
                    n_reg         <= (eff_total > {1'b0, eff_res}) ? CNT_W'(1) : '0;
                    alloc_tot_reg <= {1'b0, eff_res};
                    grp_tot_reg   <= LEN_W'(1);
                    api_tot_reg   <= '0;
                    alloc_cnt_reg <= '0;
                    free_cnt_reg  <= '0;
                    state_reg     <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (cfg_valid) begin
                        if (cfg_index == CFG_RESERVED) begin
                            reserved_reg <= cfg_data[START_W-1:0];
                        end else begin
                            total_reg <= cfg_data;
                        end
                        state_reg <= ST_INIT;
                    end else if (s_tvalid) begin
                        func_reg      <= in_func;
                        cnt_reg       <= in_cnt;
                        sb_reg        <= in_sb;
                        api_reg       <= in_api;
                        start_out_reg <= '0;
                        i_reg         <= '0;
                        largest_reg   <= '0;
                        best_vld_reg  <= 1'b0;
                        diff_reg      <= '1;
                        p_vld_reg     <= 1'b0;
                        q_vld_reg     <= 1'b0;
                        rm_pend_reg   <= 1'b0;
                        if (in_cnt == '0) begin
                            status_reg <= ST_RANGE;
                            state_reg  <= ST_LG_RD;
                        end else if (in_func == FUNC_ALLOC) begin
                            status_reg <= ST_OK;
                            state_reg  <= ST_AL_RD;
                        end else if (in_bad_range) begin
                            status_reg <= ST_RANGE;
                            state_reg  <= ST_LG_RD;
                        end else begin
                            status_reg <= ST_OK;
                            state_reg  <= ST_FR_RD;
                        end
                    end
                end
                ST_AL_RD: begin
                    if (i_reg == n_reg) begin
                        if (best_vld_reg) begin
                            state_reg <= ST_AL_UPD;
                        end else begin
                            status_reg <= ST_NOSPACE;
                            i_reg      <= '0;
                            state_reg  <= ST_LG_RD;
                        end
                    end else if (at_win_end && best_vld_reg) begin
                        state_reg <= ST_AL_UPD;
                    end else begin
                        state_reg <= ST_AL_EV;
                    end
                end
                ST_AL_EV: begin
                    // Inside the window an exact fit ends the search; past it
                    // the first group that is large enough is taken.
                    if ((in_win && cmp.len_eq) || (!in_win && cmp.len_ge)) begin
                        best_vld_reg   <= 1'b1;
                        best_idx_reg   <= i_reg[IDX_W-1:0];
                        best_start_reg <= ent_start;
                        best_len_reg   <= ent_len;
                        state_reg      <= ST_AL_UPD;
                    end else begin
                        if (in_win && cmp.better) begin
                            best_vld_reg   <= 1'b1;
                            best_idx_reg   <= i_reg[IDX_W-1:0];
                            best_start_reg <= ent_start;
                            best_len_reg   <= ent_len;
                            diff_reg       <= cmp.sub;
                        end
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= ST_AL_RD;
                    end
                end
                ST_AL_UPD: begin
                    start_out_reg <= best_start_reg;
                    alloc_tot_reg <= alloc_tot_reg + cnt_reg;
                    grp_tot_reg   <= grp_tot_reg + LEN_W'(1);
                    alloc_cnt_reg <= alloc_cnt_reg + 32'd1;
                    if (api_reg) begin
                        api_tot_reg <= api_tot_reg + LEN_W'(1);
                    end
                    i_reg <= '0;
                    if (best_len_reg == cnt_reg) begin
                        rm_idx_reg <= best_idx_reg;
                        state_reg  <= ST_RM_START;
                    end else begin
                        state_reg <= ST_LG_RD;
                    end
                end
                ST_FR_RD: begin
                    state_reg <= (i_reg == n_reg) ? ST_FR_DEC : ST_FR_EV;
                end
                ST_FR_EV: begin
                    if (cmp.overlap) begin
                        status_reg <= ST_RANGE;
                        i_reg      <= '0;
                        state_reg  <= ST_LG_RD;
                    end else begin
                        if (cmp.p_hit) begin
                            p_vld_reg   <= 1'b1;
                            p_idx_reg   <= i_reg[IDX_W-1:0];
                            p_start_reg <= ent_start;
                            p_len_reg   <= ent_len;
                        end
                        if (cmp.q_hit) begin
                            q_vld_reg <= 1'b1;
                            q_idx_reg <= i_reg[IDX_W-1:0];
                            q_len_reg <= ent_len;
                        end
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= ST_FR_RD;
                    end
                end
                ST_FR_DEC: begin
                    i_reg <= '0;
                    if (!p_vld_reg && !q_vld_reg
                        && (32'(n_reg) >= 32'(MAX_FREE_GROUPS))) begin
                        // No neighbor to merge with and no room for a new group.
                        status_reg <= ST_RANGE;
                        state_reg  <= ST_LG_RD;
                    end else begin
                        ns_reg <= p_vld_reg ? p_start_reg : sb_reg;
                        nl_reg <= cnt_reg + (p_vld_reg ? p_len_reg : '0)
                                          + (q_vld_reg ? q_len_reg : '0);
                        alloc_tot_reg <= alloc_tot_reg - cnt_reg;
                        free_cnt_reg  <= free_cnt_reg + 32'd1;
                        if (grp_tot_reg != '0) begin
                            grp_tot_reg <= grp_tot_reg - LEN_W'(1);
                        end
                        if (api_reg && (api_tot_reg != '0)) begin
                            api_tot_reg <= api_tot_reg - LEN_W'(1);
                        end
                        // With two neighbors the later one goes first, so the
                        // index of the earlier one stays valid.
                        if (p_vld_reg && q_vld_reg) begin
                            rm_idx_reg  <= (p_idx_reg > q_idx_reg) ? p_idx_reg : q_idx_reg;
                            rm2_idx_reg <= (p_idx_reg > q_idx_reg) ? q_idx_reg : p_idx_reg;
                            rm_pend_reg <= 1'b1;
                            state_reg   <= ST_RM_START;
                        end else if (p_vld_reg) begin
                            rm_idx_reg <= p_idx_reg;
                            state_reg  <= ST_RM_START;
                        end else if (q_vld_reg) begin
                            rm_idx_reg <= q_idx_reg;
                            state_reg  <= ST_RM_START;
                        end else begin
                            state_reg <= ST_APPEND;
                        end
                    end
                end
                ST_RM_START: begin
                    i_reg     <= CNT_W'(rm_idx_reg) + CNT_W'(1);
                    state_reg <= ST_RM_RD;
                end
                ST_RM_RD: begin
                    if (i_reg >= n_reg) begin
                        n_reg <= n_reg - CNT_W'(1);
                        if (rm_pend_reg) begin
                            rm_pend_reg <= 1'b0;
                            rm_idx_reg  <= rm2_idx_reg;
                            state_reg   <= ST_RM_START;
                        end else begin
                            i_reg     <= '0;
                            state_reg <= (func_reg == FUNC_FREE) ? ST_APPEND : ST_LG_RD;
                        end
                    end else begin
                        state_reg <= ST_RM_WR;
                    end
                end
                ST_RM_WR: begin
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= ST_RM_RD;
                end
                ST_APPEND: begin
                    n_reg     <= n_reg + CNT_W'(1);
                    i_reg     <= '0;
                    state_reg <= ST_LG_RD;
                end
                ST_LG_RD: begin
                    state_reg <= (i_reg == n_reg) ? ST_OUT : ST_LG_EV;
                end
                ST_LG_EV: begin
                    if (cmp.bigger) begin
                        largest_reg <= ent_len;
                    end
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= ST_LG_RD;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {largest_reg, free_cnt_reg, alloc_cnt_reg,
                                         api_tot_reg, grp_tot_reg, alloc_tot_reg,
                                         start_out_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bfba_list_ram.sv @@
// ----------------------------------------------------------------------------
// bfba_list_ram
// Free-list storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_list_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 25
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/bfba_cmp.sv @@
// ----------------------------------------------------------------------------
// bfba_cmp
// Shared compare unit: tests one free-list entry against the request.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_cmp import bfba_pkg::*; (
    input  wire logic [START_W-1:0] ent_start,
    input  wire logic [LEN_W-1:0]   ent_len,
    input  wire logic [LEN_W-1:0]   want,
    input  wire logic [START_W-1:0] sb,
    input  wire logic [LEN_W:0]     end_blk,
    input  wire logic [LEN_W-1:0]   diff,
    input  wire logic [LEN_W-1:0]   largest,
    output cmp_res_t                res
);

    logic [LEN_W:0] ent_end;
    logic           len_gt;

    assign ent_end = {2'b00, ent_start} + {1'b0, ent_len};
    assign len_gt  = ent_len > want;

    always_comb begin
        res.len_eq  = ent_len == want;
        res.len_ge  = ent_len >= want;
        res.sub     = ent_len - want;
        res.better  = len_gt && (res.sub < diff);
        // The freed range overlaps a block that is already free.
        res.overlap = ({2'b00, ent_start} < end_blk) && ({2'b00, sb} < ent_end);
        res.p_hit   = ent_end == {2'b00, sb};
        res.q_hit   = {2'b00, ent_start} == end_blk;
        res.bigger  = ent_len > largest;
    end

endmodule

`default_nettype wire

@@ hw/rtl/bfba_checker.sv @@
// ----------------------------------------------------------------------------
// bfba_checker
// Port-level checks of the best-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "best_fit_block_allocator_defines.svh"

module bfba_checker import bfba_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic [S_TUSER_W-1:0]  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [M_TUSER_W-1:0]  m_tuser,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // A stalled result holds its value.
    `BFBA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // The block works on one request at a time.
    `BFBA_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready,
        !s_tready && !cfg_ready, "request taken while busy")

    // A configuration write starts a rebuild before the next request.
    `BFBA_ASSERT_NEXT(a_rebuild, aclk, aresetn, cfg_valid && cfg_ready,
        !s_tready, "request taken during rebuild")

    // Only defined status codes are returned.
    `BFBA_ASSERT_SAME(a_status, aclk, aresetn, m_tvalid,
        (m_tuser == ST_OK) || (m_tuser == ST_NOSPACE) || (m_tuser == ST_RANGE),
        "undefined status code")

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (.*);

`default_nettype wire
